// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is held
`define EPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tachometer assertion failed");

// clocked property that also holds through reset
`define EPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tachometer assertion failed");

`endif

// ===== rtl/ept_pkg.sv =====
// types, constants and the speed band table of the edge period tachometer
`timescale 1ns / 1ps

package ept_pkg;

    // field widths
    localparam int TS_W   = 48;
    localparam int HZ_W   = 10;
    localparam int RPM_W  = 13;
    localparam int MULT_W = 13;
    localparam int DIV_W  = 22;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PROD_W = 20;

    // request kinds carried in s_tuser
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // scaling constants
    localparam logic [HZ_W-1:0] MAX_HZ_RESET = 10'd300;
    localparam int MAX_PERIOD_US = 2000000;
    localparam int HZ_SCALE      = 2000000;
    localparam int NUM_BANDS     = 11;

    // divide by 100 as a multiply by ceil(2^26 / 100) and a shift, exact below 2^20
    localparam logic [PROD_W-1:0] RPM_RECIP = 20'd671089;
    localparam int RPM_SHIFT = 26;

    typedef logic [HZ_W-1:0]   hz_t;
    typedef logic [RPM_W-1:0]  rpm_t;
    typedef logic [MULT_W-1:0] mult_t;
    typedef logic [DIV_W-1:0]  div_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_HZ_DIV,
        ST_MUL,
        ST_RPM_DIV,
        ST_DONE
    } ept_state_t;

    // divider request and response
    typedef struct packed {
        logic      start;
        div_word_t num;
        div_word_t den;
    } div_req_t;

    typedef struct packed {
        logic      done;
        div_word_t quot;
    } div_rsp_t;

    // band upper limits and multipliers in hundredths
    localparam hz_t BAND_TOP [NUM_BANDS] = '{
        10'd8, 10'd11, 10'd17, 10'd25, 10'd56, 10'd92,
        10'd123, 10'd157, 10'd188, 10'd220, 10'd262
    };
    localparam mult_t BAND_MULT [NUM_BANDS] = '{
        13'd5000, 13'd4545, 13'd4118, 13'd4000, 13'd3448, 13'd3261,
        13'd3252, 13'd3185, 13'd3191, 13'd3182, 13'd3054
    };

    // multiplier of the first band that holds hz, zero outside the table
    function automatic mult_t band_mult(input hz_t hz);
        mult_t m;
        m = '0;
        for (int i = NUM_BANDS - 1; i >= 0; i--)
        begin
            if (hz <= BAND_TOP[i])
                m = BAND_MULT[i];
        end
        if (hz == '0)
            m = '0;
        return m;
    endfunction

endpackage

// ===== rtl/ept_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ept_div
    import ept_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    div_word_t         rem_reg, rem_next;
    div_word_t         quo_reg, quo_next;
    div_word_t         den_reg, den_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              take;

    // one shift-subtract step
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== rtl/edge_period_tachometer_unit.sv =====
// Engine speed from falling edge spacing. An edge request (s_tuser = 0) stores its
// timestamp and gives no result. An update request (s_tuser = 1) finds
// round(1e6 / period) on a 22-step restoring divider, picks the speed band multiplier,
// forms the band product and divides it by 100 with a reciprocal multiply. After the
// update is accepted the sequencer checks the period (ST_PERIOD), waits for the
// division (ST_HZ_DIV), forms the band product (ST_MUL), scales it (ST_RPM_DIV) and
// loads the output register (ST_DONE). A zero period or a period above 2 s skips
// straight from ST_PERIOD to ST_DONE. s_tready stays low until the result is loaded,
// so no new request is taken while an update runs. While an earlier result still
// waits for m_tready in the output register, new requests are taken, but an update
// holds in its last step until that register frees. max_valid_hz is written through
// cfg_valid/cfg_data, resets to 300 and should only change while no update is running.
`timescale 1ns / 1ps

module edge_period_tachometer_unit
    import ept_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timestamp_us[47:0]
    input  logic [0:0]  s_tuser,   // opcode[0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // engine_rpm[12:0], rpm_changed[13],
                                   // frequency_hz[23:14], frequency_valid[24], zero
    // limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data   // max_valid_hz[9:0]
);

    ept_state_t           state_reg, state_next;
    logic [TS_W-1:0]      newest_reg, newest_next;
    logic [TS_W-1:0]      prev_reg, prev_next;
    logic [TS_W-1:0]      period;
    hz_t                  max_reg, max_next;
    hz_t                  hz_reg, hz_next;
    logic                 valid_reg, valid_next;
    mult_t                mult_reg, mult_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    rpm_t                 rpm_reg, rpm_next;
    rpm_t                 last_rpm_reg, last_rpm_next;
    logic                 reported_reg, reported_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_data_reg, m_data_next;
    logic [PROD_W-1:0]    product;
    logic [2*PROD_W-1:0]  scaled;
    logic                 changed;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    ept_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign period   = newest_reg - prev_reg;
    // band product stays below 2^20 for every table entry
    assign product  = {{(PROD_W-HZ_W){1'b0}}, hz_reg} * {{(PROD_W-MULT_W){1'b0}}, mult_reg};
    // divide by 100 through the reciprocal
    assign scaled   = {{PROD_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RPM_RECIP};
    assign changed  = !reported_reg || (rpm_reg != last_rpm_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        prev_next     = prev_reg;
        max_next      = max_reg;
        hz_next       = hz_reg;
        valid_next    = valid_reg;
        mult_next     = mult_reg;
        prod_next     = prod_reg;
        rpm_next      = rpm_reg;
        last_rpm_next = last_rpm_reg;
        reported_next = reported_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        div_req       = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        if (cfg_valid)
            max_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == OP_UPDATE)
                        state_next = ST_PERIOD;
                    else
                    begin
                        prev_next   = newest_reg;
                        newest_next = s_tdata;
                    end
                end
            end
            ST_PERIOD:
            begin
                if (period == '0)
                begin
                    valid_next = 1'b0;
                    hz_next    = '0;
                    rpm_next   = '0;
                    state_next = ST_DONE;
                end
                else if (period > TS_W'(MAX_PERIOD_US))
                begin
                    // rounds to zero hz, still valid unless the limit is zero
                    valid_next = (max_reg != '0);
                    hz_next    = '0;
                    rpm_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(HZ_SCALE) + period[DIV_W-1:0];
                    div_req.den   = {period[DIV_W-2:0], 1'b0};
                    state_next    = ST_HZ_DIV;
                end
            end
            ST_HZ_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot < DIV_W'(max_reg))
                    begin
                        valid_next = 1'b1;
                        hz_next    = div_rsp.quot[HZ_W-1:0];
                        mult_next  = band_mult(div_rsp.quot[HZ_W-1:0]);
                    end
                    else
                    begin
                        valid_next = 1'b0;
                        hz_next    = '0;
                        mult_next  = '0;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = product;
                state_next = ST_RPM_DIV;
            end
            ST_RPM_DIV:
            begin
                rpm_next   = scaled[RPM_SHIFT+RPM_W-1:RPM_SHIFT];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {7'b0, valid_reg, hz_reg, changed, rpm_reg};
                    last_rpm_next = rpm_reg;
                    reported_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            newest_reg   <= '0;
            prev_reg     <= '0;
            max_reg      <= MAX_HZ_RESET;
            last_rpm_reg <= '0;
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            newest_reg   <= newest_next;
            prev_reg     <= prev_next;
            max_reg      <= max_next;
            last_rpm_reg <= last_rpm_next;
            reported_reg <= reported_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hz_reg     <= hz_next;
        valid_reg  <= valid_next;
        mult_reg   <= mult_next;
        prod_reg   <= prod_next;
        rpm_reg    <= rpm_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/ept_checker.sv =====
// port-level checks of the edge period tachometer and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ept_checker
    import ept_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic update_accept;
    logic edge_accept;
    logic invalid_out;
    logic zero_payload;

    // accepted request kinds and result shape
    assign update_accept = s_tvalid && s_tready && (s_tuser[0] == OP_UPDATE);
    assign edge_accept   = s_tvalid && s_tready && (s_tuser[0] == OP_EDGE);
    assign invalid_out   = m_tvalid && !m_tdata[24];
    assign zero_payload  = (m_tdata[23:14] == 10'd0) && (m_tdata[12:0] == 13'd0);

    // a stalled result stays offered
    `EPT_ASSERT(a_result_held, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid)

    // an update request blocks the input while it is computed
    `EPT_ASSERT(a_update_busy, clk, rst_n, update_accept |=> !s_tready)

    // an edge request never produces a result
    `EPT_ASSERT(a_edge_silent, clk, rst_n, edge_accept && !m_tvalid |=> !m_tvalid)

    // an invalid measurement reports zero frequency and zero speed
    `EPT_ASSERT_ALWAYS(a_invalid_zero, clk, invalid_out |-> zero_payload)

endmodule

bind edge_period_tachometer_unit ept_checker u_ept_checker (.*);

// ===== bench/tb_edge_period_tachometer_unit.sv =====
// testbench of the edge period tachometer: requests checked against a speed predictor
`timescale 1ns / 1ps

module tb_edge_period_tachometer_unit
    import ept_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 133;

    // one speed report as the block should deliver it
    typedef struct packed {
        rpm_t rpm;
        logic changed;
        hz_t  hz;
        logic valid;
    } speed_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // timestamp_us[47:0]
    logic [0:0]  s_tuser = '0;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // engine_rpm[12:0], rpm_changed[13],
                                 // frequency_hz[23:14], frequency_valid[24], zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;  // max_valid_hz[9:0]

    // predicted state of the block
    logic [47:0]   newest_edge_us = '0;
    logic [47:0]   prior_edge_us = '0;
    rpm_t          last_reported_rpm = '0;
    logic          rpm_seen = 1'b0;
    hz_t           limit_hz = MAX_HZ_RESET;
    speed_report_t pending_reports [$];

    // stimulus bookkeeping
    logic [47:0] edge_clock = '0;
    int          burst_left = 0;
    int          sent_count = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          stall_mode = 0;

    edge_period_tachometer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endtask

    function automatic logic [47:0] random_stamp();
        logic [15:0] upper;
        upper = 16'($urandom());
        return {upper, $urandom()};
    endfunction

    // send one request in bursts with random gaps, then predict its result
    task automatic send_request(input logic op, input logic [47:0] stamp);
        logic [47:0] period;
        logic [63:0] hz;
        logic [63:0] cents;
        logic [63:0] rpm_full;
        logic        ok;
        speed_report_t report;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        sent_count++;

        // edge requests only shift the stored edge times
        if (op == OP_EDGE)
        begin
            prior_edge_us  = newest_edge_us;
            newest_edge_us = stamp;
        end
        else
        begin
            period = newest_edge_us - prior_edge_us;
            hz = '0;
            ok = 1'b0;
            if (period != '0)
            begin
                if (period <= 48'd2000000)
                    hz = (64'd2000000 + 64'(period)) / (64'd2 * 64'(period));
                ok = (hz < 64'(limit_hz));
            end
            if (!ok)
                hz = '0;

            // band multiplier in hundredths
            cents = '0;
            if (hz == '0)
                cents = '0;
            else if (hz <= 8)
                cents = 5000;
            else if (hz <= 11)
                cents = 4545;
            else if (hz <= 17)
                cents = 4118;
            else if (hz <= 25)
                cents = 4000;
            else if (hz <= 56)
                cents = 3448;
            else if (hz <= 92)
                cents = 3261;
            else if (hz <= 123)
                cents = 3252;
            else if (hz <= 157)
                cents = 3185;
            else if (hz <= 188)
                cents = 3191;
            else if (hz <= 220)
                cents = 3182;
            else if (hz <= 262)
                cents = 3054;
            rpm_full = (hz * cents) / 64'd100;

            report.rpm     = rpm_full[12:0];
            report.changed = !rpm_seen || (report.rpm != last_reported_rpm);
            report.hz      = hz[9:0];
            report.valid   = ok;
            pending_reports.push_back(report);
            last_reported_rpm = report.rpm;
            rpm_seen = 1'b1;
        end
    endtask

    // next edge a given period after the previous one, then an update
    task automatic pulse_and_update(input logic [47:0] period);
        edge_clock = edge_clock + period;
        send_request(OP_EDGE, edge_clock);
        send_request(OP_UPDATE, random_stamp());
    endtask

    // stop sending, wait for every result, then let the block go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input hz_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_hz = value;
    endtask

    // reset limit: update before edges, timer wrap, zero and long periods, band edges
    task automatic test_startup_cases();
        send_request(OP_UPDATE, random_stamp());
        send_request(OP_UPDATE, random_stamp());
        send_request(OP_EDGE, 48'h0);
        send_request(OP_EDGE, 48'hFFFF_FFFF_FFFF);
        send_request(OP_UPDATE, 48'hFFFF_FFFF_FFFF);
        send_request(OP_EDGE, 48'h0);
        send_request(OP_UPDATE, 48'h0);
        send_request(OP_EDGE, 48'h0);
        send_request(OP_UPDATE, random_stamp());
        edge_clock = '0;
        pulse_and_update(48'd2000000);
        pulse_and_update(48'd2000001);
        pulse_and_update(48'd80000);
        pulse_and_update(48'd125000);
        pulse_and_update(48'd3817);
        pulse_and_update(48'd3802);
        pulse_and_update(48'd3333);
        pulse_and_update(48'd3345);
    endtask

    // highest, lowest and zero limit around their boundaries
    task automatic test_limit_extremes();
        hz_t limits [3];
        limits = '{10'd1023, 10'd1, 10'd0};
        foreach (limits[i])
        begin
            settle_block();
            write_limit(limits[i]);
            pulse_and_update(48'd977);
            pulse_and_update(48'd978);
            pulse_and_update(48'd1);
            pulse_and_update(48'd2000000);
            pulse_and_update(48'd2000001);
            pulse_and_update(48'd3817);
        end
    endtask

    // mostly edge and update pairs at random speeds, mixed with odd requests
    task automatic test_random_traffic();
        int          kind;
        int          target_hz;
        int          phase_end;
        logic [47:0] period;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_block();
            case ($urandom_range(0, 5))
                0: write_limit(MAX_HZ_RESET);
                1: write_limit(HZ_W'($urandom_range(0, 20)));
                default: write_limit(HZ_W'($urandom_range(1, 1023)));
            endcase
            phase_end = sent_count + PHASE_REQUESTS;
            while (sent_count < phase_end)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 60)
                begin
                    // speed in the table or just above it
                    target_hz = ($urandom_range(0, 3) == 0) ? $urandom_range(263, 1100)
                                                            : $urandom_range(1, 262);
                    period = 48'(1000000 / target_hz + $urandom_range(0, 4) - 2);
                    pulse_and_update(period);
                end
                else if (kind < 68)
                begin
                    // around the longest period, or at random over the timer range
                    if ($urandom_range(0, 1) == 0)
                        period = 48'd2000000 + 48'($urandom_range(0, 3)) - 48'd1;
                    else
                        period = random_stamp() >> $urandom_range(0, 24);
                    pulse_and_update(period);
                end
                else if (kind < 73)
                begin
                    // zero period
                    send_request(OP_EDGE, edge_clock);
                    send_request(OP_UPDATE, random_stamp());
                end
                else if (kind < 78)
                begin
                    // jump anywhere on the timer, wrapping now and then
                    edge_clock = random_stamp();
                    send_request(OP_EDGE, edge_clock);
                    pulse_and_update(48'($urandom_range(1, 30000)));
                end
                else if (kind < 88)
                    send_request(OP_UPDATE, random_stamp());
                else
                begin
                    edge_clock = random_stamp();
                    send_request(OP_EDGE, edge_clock);
                end
            end
        end
    endtask

    // result receiver stalls in modes that change now and then
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(64, 512);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // compare each result with the oldest pending report
    always @(posedge clk)
    begin : check_results
        speed_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("unrequested result", 64'd0, 64'(m_tdata));
            else
            begin
                want = pending_reports.pop_front();
                if (m_tdata[12:0] !== want.rpm)
                    report_mismatch("engine_rpm", 64'(want.rpm), 64'(m_tdata[12:0]));
                if (m_tdata[13] !== want.changed)
                    report_mismatch("rpm_changed", 64'(want.changed), 64'(m_tdata[13]));
                if (m_tdata[23:14] !== want.hz)
                    report_mismatch("frequency_hz", 64'(want.hz), 64'(m_tdata[23:14]));
                if (m_tdata[24] !== want.valid)
                    report_mismatch("frequency_valid", 64'(want.valid), 64'(m_tdata[24]));
            end
        end
    end

    // end the run when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_edge_period_tachometer_unit failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_startup_cases();
        test_limit_extremes();
        test_random_traffic();
        settle_block();
        if (fail_count == 0)
            $display("tb_edge_period_tachometer_unit passed");
        else
            $display("tb_edge_period_tachometer_unit failed");
        $finish;
    end

endmodule
